// File: rtl/accel_offset_calibrator_assert.svh
// Assertion macros shared by the accelerometer offset calibrator RTL.
`ifndef ACCEL_OFFSET_CALIBRATOR_ASSERT_SVH
`define ACCEL_OFFSET_CALIBRATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge of i_clk outside reset.
`define AOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define AOC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define AOC_ASSERT(label, prop, msg)
`define AOC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: rtl/aoc_pkg.sv
// Types and constants of the accelerometer offset calibrator.
`default_nettype none

package aoc_pkg;

    localparam int SAMPLES_DEF   = 400;
    localparam int AXIS_BITS_DEF = 16;

    localparam int SUM_BITS  = 25;
    localparam int OFFZ_BITS = 17;
    localparam int CNT_BITS  = 9;
    localparam int BIAS_BITS = 10;

    localparam logic [BIAS_BITS-1:0] BIAS_RESET = 10'd265;
    localparam int READY_BIT = 7;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    // Steps of the offset division sequencer, one axis per step, then a drain step.
    typedef enum logic [1:0] {
        STEP_X     = 2'd0,
        STEP_Y     = 2'd1,
        STEP_Z     = 2'd2,
        STEP_DRAIN = 2'd3
    } t_div_step;

endpackage

`default_nettype wire

// File: rtl/accel_offset_calibrator.sv
// Accelerometer offset calibrator: averaging calibration and offset removal.
//
// Input beats on s_axis carry one three-axis reading with its status byte, or,
// with s_axis_tuser set, a command that starts a new calibration. Every input
// beat yields exactly one output beat on m_axis, in order. While calibrating,
// ready readings are summed; after SAMPLES of them the offsets are the sums
// divided by SAMPLES (z also less the gravity bias). In run mode a ready
// reading is returned minus the offsets, z negated.
// The block has an input register and a result register: an accepted beat
// moves from the input register into the result register, which drives m_axis,
// and one beat can be accepted every cycle while m_axis_tready holds and no
// division runs. A stalled receiver holds the result register; the input
// register still takes one more beat, after which s_axis_tready falls.
// The beat that completes a calibration starts a shared reciprocal multiplier
// that forms the three offsets one axis a cycle; s_axis_tready is low while it
// runs, so the following beat sees the new offsets.
// The gravity bias is written on the cfg channel, which is always ready, and
// should be written only while no beat is in flight.
// Reset (i_rst_n low, synchronous) empties both registers, clears the sums,
// the count and the offsets, selects run mode and sets the bias to 265.
`default_nettype none

`include "accel_offset_calibrator_assert.svh"

module accel_offset_calibrator #(
    parameter int SAMPLES   = aoc_pkg::SAMPLES_DEF,
    parameter int AXIS_BITS = aoc_pkg::AXIS_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel: gravity bias.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [9:0]  i_cfg_data,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // status_byte[7:0], raw_x[23:8], raw_y[39:24], raw_z[55:40]
    input  wire logic [55:0] s_axis_tdata,
    // opcode[0]
    input  wire logic [0:0]  s_axis_tuser,
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic [47:0]      m_axis_tdata,
    // sample_valid[0], calibrating[1], calibration_done[2], not_ready[3]
    output logic [3:0]       m_axis_tuser
);

    import aoc_pkg::*;

    localparam int AX_SH = 16 - AXIS_BITS;
    localparam logic [CNT_BITS-1:0] SAMPLES_C = CNT_BITS'(SAMPLES);

    // Reciprocal for exact floor division of a SUM_BITS-bit magnitude.
    localparam int RL = $clog2(SAMPLES);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (SUM_BITS + RL)) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam logic [SUM_BITS+1:0] RECIP = RECIP_WIDE[SUM_BITS+1:0];
    localparam int RAW_W  = 2 * SUM_BITS + 2;
    localparam int PROD_W = RAW_W + RL;

    function automatic logic [15:0] fit_axis(input logic [15:0] v);
        logic signed [15:0] t;
        t = $signed(v << AX_SH);
        return 16'(t >>> AX_SH);
    endfunction

    // Input register.
    logic        r_in_vld;
    t_opcode     r_in_op;
    logic [7:0]  r_in_status;
    logic [15:0] r_in_x, r_in_y, r_in_z;

    // Calibration and run state.
    logic [BIAS_BITS-1:0] r_bias;
    logic [SUM_BITS-1:0]  r_sum_x, r_sum_y, r_sum_z;
    logic [SUM_BITS-1:0]  n_sum_x, n_sum_y, n_sum_z;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_cal, n_cal;
    logic [15:0]          r_off_x, r_off_y;
    logic [OFFZ_BITS-1:0] r_off_z;
    logic                 n_clr, n_done;

    // Result register.
    logic        r_out_vld;
    logic [47:0] r_out_data;
    logic [3:0]  r_out_user;
    logic        n_valid, n_notready;
    logic [15:0] n_ax, n_ay, n_az;

    // Division sequencer.
    logic                 r_div_busy;
    t_div_step            r_div_step, n_div_step;
    logic                 r_pvld;
    t_div_step            r_pax;
    logic                 r_pneg;
    logic [PROD_W-1:0]    r_prod;
    logic [SUM_BITS-1:0]  w_sel, w_mag, w_quo, w_quo_s;
    logic [RAW_W-1:0]     w_prod_raw;

    logic        adv;
    logic [15:0] rx_e, ry_e, rz_e;

    assign adv = r_in_vld && (!r_out_vld || m_axis_tready) && !r_div_busy;

    assign s_axis_tready = !r_div_busy && (!r_in_vld || !r_out_vld || m_axis_tready);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    assign rx_e = fit_axis(r_in_x);
    assign ry_e = fit_axis(r_in_y);
    assign rz_e = fit_axis(r_in_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op     <= t_opcode'(s_axis_tuser[0]);
            r_in_status <= s_axis_tdata[7:0];
            r_in_x      <= s_axis_tdata[23:8];
            r_in_y      <= s_axis_tdata[39:24];
            r_in_z      <= s_axis_tdata[55:40];
        end
    end

    always_comb begin
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_sum_z    = r_sum_z;
        n_cnt      = r_cnt;
        n_cal      = r_cal;
        n_clr      = 1'b0;
        n_done     = 1'b0;
        n_valid    = 1'b0;
        n_notready = 1'b0;
        n_ax       = '0;
        n_ay       = '0;
        n_az       = '0;
        case (r_in_op)
            OP_START: begin
                n_sum_x = '0;
                n_sum_y = '0;
                n_sum_z = '0;
                n_cnt   = '0;
                n_cal   = 1'b1;
                n_clr   = 1'b1;
            end
            OP_READ: begin
                if (!r_in_status[READY_BIT]) begin
                    n_notready = 1'b1;
                end else if (r_cal) begin
                    n_sum_x = r_sum_x + {{(SUM_BITS-16){rx_e[15]}}, rx_e};
                    n_sum_y = r_sum_y + {{(SUM_BITS-16){ry_e[15]}}, ry_e};
                    n_sum_z = r_sum_z + {{(SUM_BITS-16){rz_e[15]}}, rz_e};
                    n_cnt   = r_cnt + CNT_BITS'(1);
                    if (n_cnt == SAMPLES_C) begin
                        n_cal  = 1'b0;
                        n_done = 1'b1;
                    end
                end else begin
                    n_valid = 1'b1;
                    n_ax    = fit_axis(rx_e - r_off_x);
                    n_ay    = fit_axis(ry_e - r_off_y);
                    // Negated difference, taken directly as offset minus sample.
                    n_az    = fit_axis(r_off_z[15:0] - rz_e);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_cnt   <= '0;
            r_cal   <= 1'b0;
        end else if (adv) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_sum_z <= n_sum_z;
            r_cnt   <= n_cnt;
            r_cal   <= n_cal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= BIAS_RESET;
        end else if (i_cfg_valid) begin
            r_bias <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {n_az, n_ay, n_ax};
            r_out_user <= {n_notready, n_done, n_cal, n_valid};
        end
    end

    // Offset division: one axis enters the multiplier per cycle, and its
    // quotient is written back in the following cycle.
    always_comb begin
        case (r_div_step)
            STEP_X:  w_sel = r_sum_x;
            STEP_Y:  w_sel = r_sum_y;
            default: w_sel = r_sum_z;
        endcase
        w_mag      = w_sel[SUM_BITS-1] ? (~w_sel + SUM_BITS'(1)) : w_sel;
        w_prod_raw = RAW_W'(w_mag) * RAW_W'(RECIP);
        w_quo      = r_prod[SUM_BITS+RL +: SUM_BITS];
        w_quo_s    = r_pneg ? (~w_quo + SUM_BITS'(1)) : w_quo;
        case (r_div_step)
            STEP_X:  n_div_step = STEP_Y;
            STEP_Y:  n_div_step = STEP_Z;
            STEP_Z:  n_div_step = STEP_DRAIN;
            default: n_div_step = STEP_DRAIN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_step <= STEP_X;
            r_pvld     <= 1'b0;
        end else begin
            r_pvld <= r_div_busy && (r_div_step != STEP_DRAIN);
            if (adv && n_done) begin
                r_div_busy <= 1'b1;
                r_div_step <= STEP_X;
            end else if (r_div_busy) begin
                r_div_step <= n_div_step;
                if (r_div_step == STEP_DRAIN) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_prod_raw);
        r_pneg <= w_sel[SUM_BITS-1];
        r_pax  <= r_div_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (adv && n_clr) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (r_pvld) begin
            case (r_pax)
                STEP_X:  r_off_x <= w_quo_s[15:0];
                STEP_Y:  r_off_y <= w_quo_s[15:0];
                STEP_Z:  r_off_z <= w_quo_s[OFFZ_BITS-1:0] - OFFZ_BITS'(r_bias);
                default: ;
            endcase
        end
    end

    `AOC_ASSERT(a_busy_blocks_input, r_div_busy |-> !s_axis_tready, "input accepted during division")
    `AOC_ASSERT(a_done_starts_div, (adv && n_done) |=> (r_div_busy && r_div_step == STEP_X), "division not started")
    `AOC_ASSERT(a_div_finishes, (r_div_busy && r_div_step == STEP_DRAIN) |=> !r_div_busy, "division overran")
    `AOC_ASSERT(a_count_bound, r_cnt <= SAMPLES_C, "sample count beyond limit")
    `AOC_ASSERT(a_done_exclusive, (m_axis_tvalid && m_axis_tuser[2]) |-> (!m_axis_tuser[1] && !m_axis_tuser[0]), "done beat flags inconsistent")

endmodule

`default_nettype wire
